// ----- src/tfe_pkg.sv -----
// ============================================================================
// Easing evaluator package
// Shared widths, fixed-point types, register codes and rounding helpers.
// ============================================================================
`default_nettype none

package tfe_pkg;

    // Newton steps used to invert the x curve.
    localparam int NEWTON_ITERATIONS = 8;
    // Fraction bits of the progress, control point and result words.
    localparam int FRAC_BITS         = 16;
    // Fraction bits of the internal Bezier arithmetic.
    localparam int WBITS             = 24;
    localparam int UP_SHIFT          = WBITS - FRAC_BITS;
    // Quotient bits of the stepped-mode divider.
    localparam int STEP_DIV_BITS     = FRAC_BITS;

    // Pipeline depths of the parts of the block.
    localparam int EVAL_STAGES   = 3;
    localparam int NEWTON_STAGES = EVAL_STAGES + WBITS + 2;
    localparam int STEPS_STAGES  = STEP_DIV_BITS + 4;
    localparam int LATENCY       = STEPS_STAGES + NEWTON_ITERATIONS * NEWTON_STAGES
                                   + EVAL_STAGES + 1;

    typedef logic signed [31:0] t_q24;
    typedef logic signed [63:0] t_prod;

    localparam t_q24        ONE_W     = t_q24'(longint'(1) << WBITS);
    localparam t_q24        RESID_EPS = t_q24'(17);
    localparam logic [16:0] ONE_IO    = 17'(1 << FRAC_BITS);
    localparam t_q24        EASE_LIM  = t_q24'(8 << FRAC_BITS);

    typedef enum logic [1:0] {
        POS_JUMP_START = 2'd0,
        POS_JUMP_END   = 2'd1,
        POS_JUMP_NONE  = 2'd2,
        POS_JUMP_BOTH  = 2'd3
    } t_step_pos;

    typedef enum logic [2:0] {
        REG_CURVE_MODE    = 3'd0,
        REG_CTRL_X1       = 3'd1,
        REG_CTRL_Y1       = 3'd2,
        REG_CTRL_X2       = 3'd3,
        REG_CTRL_Y2       = 3'd4,
        REG_STEP_COUNT    = 3'd5,
        REG_STEP_POSITION = 3'd6
    } t_reg_idx;

    // Context that travels with each word down the pipeline.
    typedef struct packed {
        logic        mode;
        logic        done;
        t_q24        tw;
        t_q24        u;
        logic [16:0] sres;
    } t_ctx;

    // Round a double-width product back to Q24, ties towards plus infinity.
    function automatic t_q24 rnd_w(input t_prod x);
        t_prod s;
        s = (x + (t_prod'(1) <<< (WBITS - 1))) >>> WBITS;
        return t_q24'(s);
    endfunction

    // Signed product of two Q24 words.
    function automatic t_prod mul(input t_q24 a, input t_q24 b);
        return t_prod'(a) * t_prod'(b);
    endfunction

endpackage

`default_nettype wire

// ----- src/tfe_steps.sv -----
// ============================================================================
// Easing evaluator front end
// Clamps the progress, builds the word context and computes the stepped
// result with a pipelined restoring divider.
// ============================================================================
`default_nettype none

module tfe_steps (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic signed [18:0] i_progress,
    input  wire logic          i_mode,
    input  wire logic [9:0]    i_step_count,
    input  wire logic [1:0]    i_step_position,
    output logic               o_valid,
    output tfe_pkg::t_ctx      o_ctx
);
    import tfe_pkg::*;

    localparam int ND = STEP_DIV_BITS;

    logic        r_v0, r_v1;
    logic [16:0] r_t;
    logic [9:0]  r_n;
    t_step_pos   r_pos;
    t_ctx        r_ctx0, r_ctx1;
    logic [10:0] r_i, r_den;

    logic [16:0] n_t;
    logic [9:0]  n_n;
    t_ctx        n_ctx0;
    logic [25:0] n_prod;
    logic [10:0] n_i, n_den;
    logic [26:0] n_num;

    logic        r_valid [0:ND];
    t_ctx        r_ctx   [0:ND];
    logic [10:0] r_rem   [0:ND];
    logic [15:0] r_low   [0:ND];
    logic [15:0] r_quo   [0:ND];
    logic [11:0] r_d2    [0:ND];
    logic        r_full  [0:ND];
    logic        r_zero  [0:ND];

    logic [11:0] n_sh  [1:ND];
    logic        n_ge  [1:ND];
    logic [10:0] n_rem [1:ND];

    t_ctx        n_ctx_out;

    // Clamp the progress and build the context of the word.
    always_comb begin
        if (i_progress < 19'sd0) begin
            n_t = 17'd0;
        end else if (i_progress > $signed({2'b00, ONE_IO})) begin
            n_t = ONE_IO;
        end else begin
            n_t = i_progress[16:0];
        end
        n_n           = (i_step_count == 10'd0) ? 10'd1 : i_step_count;
        n_ctx0.mode   = i_mode;
        n_ctx0.done   = 1'b0;
        n_ctx0.tw     = t_q24'(n_t) <<< UP_SHIFT;
        n_ctx0.u      = t_q24'(n_t) <<< UP_SHIFT;
        n_ctx0.sres   = 17'd0;
    end

    // Step index and divisor from the jump position.
    always_comb begin
        n_prod = 26'(r_t) * 26'(r_n);
        n_i    = {1'b0, n_prod[25:16]};
        if (r_pos == POS_JUMP_START || r_pos == POS_JUMP_BOTH) begin
            n_i = n_i + 11'd1;
        end
        case (r_pos)
            POS_JUMP_NONE: n_den = (r_n > 10'd1) ? {1'b0, r_n - 10'd1} : 11'd1;
            POS_JUMP_BOTH: n_den = {1'b0, r_n} + 11'd1;
            default:       n_den = {1'b0, r_n};
        endcase
    end

    // Rounded quotient numerator: 2*i*one + denom over 2*denom.
    assign n_num = {r_i[9:0], 17'd0} + 27'(r_den);

    // One quotient bit per stage.
    always_comb begin
        for (int k = 1; k <= ND; k++) begin
            n_sh[k]  = {r_rem[k-1], r_low[k-1][15]};
            n_ge[k]  = n_sh[k] >= r_d2[k-1];
            n_rem[k] = n_ge[k] ? 11'(n_sh[k] - r_d2[k-1]) : n_sh[k][10:0];
        end
    end

    // Final selection of the stepped result.
    always_comb begin
        n_ctx_out = r_ctx[ND];
        if (r_full[ND]) begin
            n_ctx_out.sres = ONE_IO;
        end else if (r_zero[ND]) begin
            n_ctx_out.sres = 17'd0;
        end else begin
            n_ctx_out.sres = {1'b0, r_quo[ND]};
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
            for (int k = 0; k <= ND; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            r_v0       <= i_valid;
            r_v1       <= r_v0;
            r_valid[0] <= r_v1;
            for (int k = 1; k <= ND; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
            o_valid <= r_valid[ND];
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_t       <= n_t;
        r_n       <= n_n;
        r_pos     <= t_step_pos'(i_step_position);
        r_ctx0    <= n_ctx0;
        r_i       <= n_i;
        r_den     <= n_den;
        r_ctx1    <= r_ctx0;
        r_ctx[0]  <= r_ctx1;
        r_full[0] <= r_i >= r_den;
        r_zero[0] <= r_i == 11'd0;
        r_rem[0]  <= n_num[26:16];
        r_low[0]  <= n_num[15:0];
        r_quo[0]  <= 16'd0;
        r_d2[0]   <= {r_den, 1'b0};
        for (int k = 1; k <= ND; k++) begin
            r_ctx[k]  <= r_ctx[k-1];
            r_full[k] <= r_full[k-1];
            r_zero[k] <= r_zero[k-1];
            r_rem[k]  <= n_rem[k];
            r_low[k]  <= {r_low[k-1][14:0], 1'b0};
            r_quo[k]  <= {r_quo[k-1][14:0], n_ge[k]};
            r_d2[k]   <= r_d2[k-1];
        end
        o_ctx <= n_ctx_out;
    end

endmodule

`default_nettype wire

// ----- src/tfe_eval.sv -----
// ============================================================================
// Cubic Bezier evaluator
// Three-stage pipeline giving the curve value and its slope at u.
// ============================================================================
`default_nettype none

module tfe_eval (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire tfe_pkg::t_ctx i_ctx,
    input  wire tfe_pkg::t_q24 i_p1,
    input  wire tfe_pkg::t_q24 i_p2,
    output logic               o_valid,
    output tfe_pkg::t_ctx      o_ctx,
    output tfe_pkg::t_q24      o_bez,
    output tfe_pkg::t_q24      o_slope
);
    import tfe_pkg::*;

    logic  r_v1, r_v2;
    t_ctx  r_ctx1, r_ctx2;
    t_q24  r_v, r_uu, r_vv, r_vu;
    t_q24  r_b1, r_b2, r_b3;
    t_prod r_ssum;

    t_q24  n_v, n_uu, n_vv, n_vu;
    t_q24  n_b1, n_b2, n_b3;
    t_prod n_ssum;
    t_q24  n_bez, n_slope;

    // First stage: squares and cross term of u and 1-u.
    always_comb begin
        n_v  = ONE_W - i_ctx.u;
        n_uu = rnd_w(mul(i_ctx.u, i_ctx.u));
        n_vv = rnd_w(mul(n_v, n_v));
        n_vu = rnd_w(mul(n_v, i_ctx.u));
    end

    // Second stage: Bernstein weights and the slope terms.
    always_comb begin
        n_b1   = rnd_w(3 * mul(r_vv, r_ctx1.u));
        n_b2   = rnd_w(3 * mul(r_v, r_uu));
        n_b3   = rnd_w(mul(r_uu, r_ctx1.u));
        n_ssum = 3 * mul(r_vv, i_p1) + 6 * mul(r_vu, i_p2 - i_p1)
                 + 3 * mul(r_uu, ONE_W - i_p2);
    end

    // Third stage: weighted sum of the control points and the rounded slope.
    always_comb begin
        n_bez   = rnd_w(mul(r_b1, i_p1) + mul(r_b2, i_p2)) + r_b3;
        n_slope = rnd_w(r_ssum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx1  <= i_ctx;
        r_v     <= n_v;
        r_uu    <= n_uu;
        r_vv    <= n_vv;
        r_vu    <= n_vu;
        r_ctx2  <= r_ctx1;
        r_b1    <= n_b1;
        r_b2    <= n_b2;
        r_b3    <= n_b3;
        r_ssum  <= n_ssum;
        o_ctx   <= r_ctx2;
        o_bez   <= n_bez;
        o_slope <= n_slope;
    end

endmodule

`default_nettype wire

// ----- src/tfe_newton.sv -----
// ============================================================================
// Newton step
// One pipelined Newton iteration on x(u) = t: evaluation, residual test,
// a bit-per-stage divider and the clamped update of u.
// ============================================================================
`default_nettype none

module tfe_newton (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire tfe_pkg::t_ctx i_ctx,
    input  wire tfe_pkg::t_q24 i_x1,
    input  wire tfe_pkg::t_q24 i_x2,
    output logic               o_valid,
    output tfe_pkg::t_ctx      o_ctx
);
    import tfe_pkg::*;

    localparam int NQ = WBITS;

    logic  e_valid;
    t_ctx  e_ctx;
    t_q24  e_bez, e_slope;

    t_q24        n_x;
    logic [31:0] n_xm, n_dm;
    t_ctx        n_ctx0;

    logic        r_valid [0:NQ];
    t_ctx        r_ctx   [0:NQ];
    logic [32:0] r_rem   [0:NQ];
    logic [31:0] r_dm    [0:NQ];
    logic [NQ-1:0] r_quo [0:NQ];
    logic        r_neg   [0:NQ];
    logic        r_sat   [0:NQ];

    logic [32:0] n_sh  [1:NQ];
    logic        n_ge  [1:NQ];
    logic [32:0] n_rem [1:NQ];

    t_q24 n_q, n_dq, n_un;
    t_ctx n_ctx_out;

    tfe_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ctx   (i_ctx),
        .i_p1    (i_x1),
        .i_p2    (i_x2),
        .o_valid (e_valid),
        .o_ctx   (e_ctx),
        .o_bez   (e_bez),
        .o_slope (e_slope)
    );

    // Residual test; a word that is finished keeps its u from here on.
    always_comb begin
        n_x         = e_bez - e_ctx.tw;
        n_xm        = (n_x < 0) ? 32'(-n_x) : 32'(n_x);
        n_dm        = (e_slope < 0) ? 32'(-e_slope) : 32'(e_slope);
        n_ctx0      = e_ctx;
        n_ctx0.done = e_ctx.done || (n_x > -RESID_EPS && n_x < RESID_EPS)
                      || (e_slope == 0);
    end

    // Restoring division of |x| * 2^24 by |slope|, one bit per stage.
    always_comb begin
        for (int k = 1; k <= NQ; k++) begin
            n_sh[k]  = {r_rem[k-1][31:0], 1'b0};
            n_ge[k]  = n_sh[k] >= {1'b0, r_dm[k-1]};
            n_rem[k] = n_ge[k] ? n_sh[k] - {1'b0, r_dm[k-1]} : n_sh[k];
        end
    end

    // Update of u, clamped to the unit interval. A quotient of one or more
    // always clamps, so the divider saturates there.
    always_comb begin
        n_q  = r_sat[NQ] ? ONE_W : t_q24'(r_quo[NQ]);
        n_dq = r_neg[NQ] ? -n_q : n_q;
        n_un = r_ctx[NQ].u - n_dq;
        n_ctx_out = r_ctx[NQ];
        if (!r_ctx[NQ].done) begin
            if (n_un < 0) begin
                n_ctx_out.u = t_q24'(0);
            end else if (n_un > ONE_W) begin
                n_ctx_out.u = ONE_W;
            end else begin
                n_ctx_out.u = n_un;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            for (int k = 0; k <= NQ; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            r_valid[0] <= e_valid;
            for (int k = 1; k <= NQ; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
            o_valid <= r_valid[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx[0] <= n_ctx0;
        r_rem[0] <= {1'b0, n_xm};
        r_dm[0]  <= n_dm;
        r_quo[0] <= '0;
        r_neg[0] <= (n_x < 0) != (e_slope < 0);
        r_sat[0] <= n_xm >= n_dm;
        for (int k = 1; k <= NQ; k++) begin
            r_ctx[k] <= r_ctx[k-1];
            r_rem[k] <= n_rem[k];
            r_dm[k]  <= r_dm[k-1];
            r_quo[k] <= {r_quo[k-1][NQ-2:0], n_ge[k]};
            r_neg[k] <= r_neg[k-1];
            r_sat[k] <= r_sat[k-1];
        end
        o_ctx <= n_ctx_out;
    end

endmodule

`default_nettype wire

// ----- src/timing_function_easing_eval.sv -----
// Path: stepped front end, chain of Newton steps, final y evaluation, output register.
// Throughput: one word per cycle; the divider and Bezier stages are fully pipelined.
// busy is never raised, and the result strobe cannot be held off by the receiver.
// Reset is synchronous and active low: it clears the pipeline valid bits and
// returns the configuration registers to their defaults.
// ============================================================================
// Timing-function easing evaluator
// Cubic Bezier (Newton inversion) and stepped easing of a progress word,
// with an APB-style configuration port.
// ============================================================================
`default_nettype none

module timing_function_easing_eval (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [18:0] i_progress,
    output logic                    o_valid,
    output logic signed [20:0]      o_eased,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import tfe_pkg::*;

    logic               r_curve_mode;
    logic [16:0]        r_ctrl_x1, r_ctrl_x2;
    logic signed [20:0] r_ctrl_y1, r_ctrl_y2;
    logic [9:0]         r_step_count;
    logic [1:0]         r_step_position;

    logic     cfg_wr;
    t_reg_idx cfg_idx;
    t_q24     x1w, x2w, y1w, y2w;

    logic c_valid [0:NEWTON_ITERATIONS];
    t_ctx c_ctx   [0:NEWTON_ITERATIONS];

    logic f_valid;
    t_ctx f_ctx;
    t_q24 f_bez;

    t_q24               n_yr;
    logic signed [20:0] n_eased;
    logic               r_out_mode;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Configuration registers.
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode    <= 1'b0;
            r_ctrl_x1       <= 17'd0;
            r_ctrl_y1       <= 21'sd0;
            r_ctrl_x2       <= ONE_IO;
            r_ctrl_y2       <= $signed({4'b0000, ONE_IO});
            r_step_count    <= 10'd1;
            r_step_position <= POS_JUMP_END;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_CURVE_MODE:    r_curve_mode    <= pwdata[0];
                REG_CTRL_X1:       r_ctrl_x1       <= pwdata[16:0];
                REG_CTRL_Y1:       r_ctrl_y1       <= $signed(pwdata[20:0]);
                REG_CTRL_X2:       r_ctrl_x2       <= pwdata[16:0];
                REG_CTRL_Y2:       r_ctrl_y2       <= $signed(pwdata[20:0]);
                REG_STEP_COUNT:    r_step_count    <= pwdata[9:0];
                REG_STEP_POSITION: r_step_position <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_CURVE_MODE:    prdata = {31'd0, r_curve_mode};
            REG_CTRL_X1:       prdata = {15'd0, r_ctrl_x1};
            REG_CTRL_Y1:       prdata = {11'd0, r_ctrl_y1};
            REG_CTRL_X2:       prdata = {15'd0, r_ctrl_x2};
            REG_CTRL_Y2:       prdata = {11'd0, r_ctrl_y2};
            REG_STEP_COUNT:    prdata = {22'd0, r_step_count};
            REG_STEP_POSITION: prdata = {30'd0, r_step_position};
            default:           prdata = 32'd0;
        endcase
    end

    // Control points in Q24; x is saturated to one.
    always_comb begin
        x1w = t_q24'((r_ctrl_x1 > ONE_IO) ? ONE_IO : r_ctrl_x1) <<< UP_SHIFT;
        x2w = t_q24'((r_ctrl_x2 > ONE_IO) ? ONE_IO : r_ctrl_x2) <<< UP_SHIFT;
        y1w = t_q24'(r_ctrl_y1) <<< UP_SHIFT;
        y2w = t_q24'(r_ctrl_y2) <<< UP_SHIFT;
    end

    // Front end: clamp and stepped result.
    tfe_steps u_steps (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start && !busy),
        .i_progress      (i_progress),
        .i_mode          (r_curve_mode),
        .i_step_count    (r_step_count),
        .i_step_position (r_step_position),
        .o_valid         (c_valid[0]),
        .o_ctx           (c_ctx[0])
    );

    // Chain of Newton steps.
    for (genvar g = 0; g < NEWTON_ITERATIONS; g++) begin : g_newton
        tfe_newton u_newton (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_ctx   (c_ctx[g]),
            .i_x1    (x1w),
            .i_x2    (x2w),
            .o_valid (c_valid[g+1]),
            .o_ctx   (c_ctx[g+1])
        );
    end

    // Final y evaluation at the converged u.
    tfe_eval u_eval_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[NEWTON_ITERATIONS]),
        .i_ctx   (c_ctx[NEWTON_ITERATIONS]),
        .i_p1    (y1w),
        .i_p2    (y2w),
        .o_valid (f_valid),
        .o_ctx   (f_ctx),
        .o_bez   (f_bez),
        .o_slope ()
    );

    // Round to Q16, saturate at plus or minus eight, select by mode.
    always_comb begin
        n_yr = (f_bez + (t_q24'(1) <<< (UP_SHIFT - 1))) >>> UP_SHIFT;
        if (n_yr > EASE_LIM) begin
            n_yr = EASE_LIM;
        end else if (n_yr < -EASE_LIM) begin
            n_yr = -EASE_LIM;
        end
        if (f_ctx.mode) begin
            n_eased = $signed({4'b0000, f_ctx.sres});
        end else begin
            n_eased = 21'(n_yr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_eased    <= n_eased;
        r_out_mode <= f_ctx.mode;
    end

`ifndef ASSERT_OFF
    // Every accepted word comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted word did not emerge after the pipeline latency");

    // No result appears without a word accepted that many cycles earlier.
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result strobe without a matching accepted word");

    // Stepped results always lie in the unit interval.
    a_steps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_mode) |->
        (o_eased >= 21'sd0 && o_eased <= $signed({4'b0000, ONE_IO})))
        else $error("stepped result outside the unit interval");
`endif

endmodule

`default_nettype wire

// ----- dv/timing_function_easing_eval_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Easing evaluator testbench
// Writes a series of register settings over the APB port, including the
// extremes. Each setting is followed by progress words, first from a
// directed table and then at random. Every eased word is checked against a
// table value or an in-bench predictor of cubic Bezier and stepped easing.
// ============================================================================
`default_nettype none

module timing_function_easing_eval_tb;
    import tfe_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  DRAIN_WAIT  = LATENCY + 40;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint Q24_ONE  = longint'(1) << 24;
    localparam longint Q16_ONE  = longint'(1) << 16;

    // One row of the directed table: a register write or a progress word.
    typedef struct {
        bit                 is_write;
        t_reg_idx           idx;
        logic [31:0]        value;
        logic signed [18:0] progress;
        bit                 known;
        logic signed [20:0] want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [18:0] i_progress = '0;
    logic               o_valid;
    logic signed [20:0] o_eased;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor copy of the configuration registers.
    logic        cfg_mode;
    logic [16:0] cfg_x1;
    logic [20:0] cfg_y1;
    logic [16:0] cfg_x2;
    logic [20:0] cfg_y2;
    logic [9:0]  cfg_count;
    logic [1:0]  cfg_pos;

    logic signed [20:0] eased_q[$];
    t_row               table_q[$];
    int                 mismatches = 0;
    int                 cycles = 0;

    timing_function_easing_eval dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_progress(i_progress), .o_valid(o_valid), .o_eased(o_eased),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Round a Q48 product back to Q24, ties towards plus infinity.
    function automatic longint round_q24(input longint x);
        return (x + (Q24_ONE >>> 1)) >>> 24;
    endfunction

    // One coordinate of the curve at parameter u.
    function automatic longint curve_point(input longint p1, input longint p2,
                                           input longint u);
        longint v, uu, vv, b1, b2, b3;
        v  = Q24_ONE - u;
        uu = round_q24(u * u);
        vv = round_q24(v * v);
        b1 = round_q24(3 * vv * u);
        b2 = round_q24(3 * v * uu);
        b3 = round_q24(uu * u);
        return round_q24(b1 * p1 + b2 * p2) + b3;
    endfunction

    // Derivative of one coordinate of the curve at parameter u.
    function automatic longint curve_slope(input longint p1, input longint p2,
                                           input longint u);
        longint v, uu, vv, vu;
        v  = Q24_ONE - u;
        uu = round_q24(u * u);
        vv = round_q24(v * v);
        vu = round_q24(v * u);
        return round_q24(3 * vv * p1 + 6 * vu * (p2 - p1) + 3 * uu * (Q24_ONE - p2));
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Stepped easing of a clamped Q16 progress.
    function automatic longint ease_steps(input longint t);
        longint n, i, denom;
        n = (cfg_count == 0) ? 1 : longint'(cfg_count);
        i = (t * n) >>> 16;
        if (cfg_pos == POS_JUMP_START || cfg_pos == POS_JUMP_BOTH)
            i = i + 1;
        denom = n;
        if (cfg_pos == POS_JUMP_NONE)
            denom = (n > 1) ? n - 1 : 1;
        if (cfg_pos == POS_JUMP_BOTH)
            denom = n + 1;
        if (i >= denom)
            return Q16_ONE;
        if (i <= 0)
            return 0;
        return (2 * i * Q16_ONE + denom) / (2 * denom);
    endfunction

    // Bezier easing: Newton inversion of x(u) = t, then y(u) back in Q16.
    function automatic longint ease_bezier(input longint t);
        longint x1, x2, y1, y2, tw, u, x, d, y;
        x1 = clamp(longint'(cfg_x1), 0, Q16_ONE) <<< 8;
        x2 = clamp(longint'(cfg_x2), 0, Q16_ONE) <<< 8;
        y1 = longint'($signed(cfg_y1)) <<< 8;
        y2 = longint'($signed(cfg_y2)) <<< 8;
        tw = t <<< 8;
        u  = tw;
        for (int k = 0; k < NEWTON_ITERATIONS; k++) begin
            x = curve_point(x1, x2, u) - tw;
            if (x > -17 && x < 17)
                break;
            d = curve_slope(x1, x2, u);
            if (d == 0)
                break;
            u = clamp(u - (x * Q24_ONE) / d, 0, Q24_ONE);
        end
        y = (curve_point(y1, y2, u) + 128) >>> 8;
        y = clamp(y, -8 * Q16_ONE, 8 * Q16_ONE);
        return clamp(y, -1048576, 1048575);
    endfunction

    function automatic logic signed [20:0] eased_of(input logic signed [18:0] p);
        longint t;
        t = clamp(longint'(p), 0, Q16_ONE);
        return 21'(cfg_mode ? ease_steps(t) : ease_bezier(t));
    endfunction

    // Update the predictor copy of one register.
    function automatic void note_write(input t_reg_idx idx, input logic [31:0] val);
        case (idx)
            REG_CURVE_MODE:    cfg_mode  = val[0];
            REG_CTRL_X1:       cfg_x1    = val[16:0];
            REG_CTRL_Y1:       cfg_y1    = val[20:0];
            REG_CTRL_X2:       cfg_x2    = val[16:0];
            REG_CTRL_Y2:       cfg_y2    = val[20:0];
            REG_STEP_COUNT:    cfg_count = val[9:0];
            REG_STEP_POSITION: cfg_pos   = val[1:0];
            default: ;
        endcase
    endfunction

    function automatic void add_write(input t_reg_idx idx, input logic [31:0] val);
        t_row r;
        r = '{1'b1, idx, val, '0, 1'b0, '0};
        table_q.insert(table_q.size(), r);
    endfunction

    function automatic void add_word(input logic signed [18:0] p, input bit known,
                                     input logic signed [20:0] want);
        t_row r;
        r = '{1'b0, REG_CURVE_MODE, '0, p, known, want};
        table_q.insert(table_q.size(), r);
    endfunction

    // APB write: setup cycle, then access until pready.
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        note_write(idx, val);
    endtask

    // Offer one word and wait until it is taken; start stays high afterwards.
    task automatic send_word(input logic signed [18:0] p, input bit known,
                             input logic signed [20:0] want);
        i_progress <= p;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        eased_q.insert(eased_q.size(), known ? want : eased_of(p));
    endtask

    // Let the pipeline empty before touching the registers.
    task automatic wait_idle();
        start <= 1'b0;
        while (eased_q.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic random_setup();
        logic [31:0] v;
        wait_idle();
        reg_write(REG_CURVE_MODE, 32'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 65536;
            2: v = 32'($urandom_range(65537, 131071));
            default: v = 32'($urandom_range(0, 65536));
        endcase
        reg_write(REG_CTRL_X1, v);
        reg_write(REG_CTRL_X2, ($urandom_range(0, 3) == 0) ? 32'($urandom & 32'h1FFFF)
                                                              : 32'($urandom_range(0, 65536)));
        reg_write(REG_CTRL_Y1, ($urandom_range(0, 3) == 0) ? 32'($urandom & 32'h1FFFFF)
                                                              : 32'($urandom_range(0, 98304)));
        reg_write(REG_CTRL_Y2, ($urandom_range(0, 3) == 0) ? 32'($urandom & 32'h1FFFFF)
                                                              : 32'($urandom_range(0, 98304)));
        case ($urandom_range(0, 3))
            0: v = 32'($urandom_range(0, 1));
            1: v = 1023;
            default: v = 32'($urandom_range(1, 12));
        endcase
        reg_write(REG_STEP_COUNT, v);
        reg_write(REG_STEP_POSITION, 32'($urandom_range(0, 3)));
    endtask

    // Check every eased word against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (eased_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d", $time, o_eased);
                mismatches++;
            end else begin
                if (o_eased !== eased_q[0]) begin
                    $display("%0t: eased mismatch, expected %0d, actual %0d",
                             $time, eased_q[0], o_eased);
                    mismatches++;
                end
                void'(eased_q.pop_front());
            end
        end
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int gap_pct[3];
        gap_pct = '{12, 72, 0};
        note_write(REG_CURVE_MODE, 0);
        note_write(REG_CTRL_X1, 0);
        note_write(REG_CTRL_Y1, 0);
        note_write(REG_CTRL_X2, 65536);
        note_write(REG_CTRL_Y2, 65536);
        note_write(REG_STEP_COUNT, 1);
        note_write(REG_STEP_POSITION, 1);

        // Reset defaults: progress outside 0..1 clamps to the ends.
        add_word(-262144, 1, 0);
        add_word(-1, 1, 0);
        add_word(0, 1, 0);
        add_word(32768, 0, 0);
        add_word(65536, 1, 65536);
        add_word(131072, 1, 65536);
        add_word(262143, 1, 65536);
        // Control x above one saturates; control y at the field extremes.
        add_write(REG_CTRL_X1, 131071);
        add_write(REG_CTRL_Y1, 32'h0FFFFF);
        add_write(REG_CTRL_X2, 0);
        add_write(REG_CTRL_Y2, 32'h100000);
        add_word(0, 1, 0);
        add_word(16384, 0, 0);
        add_word(49152, 0, 0);
        add_word(65536, 1, 65536);
        // Stepped mode with a zero count, which acts as one step.
        add_write(REG_CURVE_MODE, 1);
        add_write(REG_STEP_COUNT, 0);
        add_write(REG_STEP_POSITION, POS_JUMP_END);
        add_word(32768, 0, 0);
        add_word(65536, 1, 65536);
        // Jump-none with one step divides by one.
        add_write(REG_STEP_POSITION, POS_JUMP_NONE);
        add_word(0, 1, 0);
        add_word(65536, 1, 65536);
        add_write(REG_STEP_COUNT, 1023);
        add_write(REG_STEP_POSITION, POS_JUMP_START);
        add_word(0, 0, 0);
        add_word(65535, 0, 0);
        add_write(REG_STEP_POSITION, POS_JUMP_BOTH);
        add_word(65536, 1, 65536);
        add_word(30000, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (table_q[r]) begin
            if (table_q[r].is_write) begin
                wait_idle();
                reg_write(table_q[r].idx, table_q[r].value);
            end else begin
                send_word(table_q[r].progress, table_q[r].known, table_q[r].want);
            end
        end

        // Random words in three idling phases, with a fresh setting every 90 words.
        // Each cycle after a word idles with the phase's chance, so that share
        // of the cycles carries no word.
        for (int ph = 0; ph < 3; ph++) begin
            for (int n = 0; n < 534; n++) begin
                if (n % 90 == 0)
                    random_setup();
                if ($urandom_range(0, 7) == 0)
                    send_word(19'($urandom), 0, 0);
                else
                    send_word(19'($urandom_range(0, 65536)), 0, 0);
                while ($urandom_range(0, 99) < gap_pct[ph]) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                end
            end
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/tfe_pkg.sv
src/tfe_steps.sv
src/tfe_eval.sv
src/tfe_newton.sv
src/timing_function_easing_eval.sv
dv/timing_function_easing_eval_tb.sv
